/* hdl/hsd_pkg.sv */
// shared types and constants of the huffman table search decoder
`default_nettype none
package hsd_pkg;

  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned MAX_CODE_BITS = 31;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned RES_DEPTH     = 2;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CODE_W  = 31;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RPTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RCNT_W  = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_BIT   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_BIT   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  entry_symbol;
    logic [LEN_W-1:0]  entry_length;
    logic [CODE_W-1:0] entry_code;
    logic              code_bit;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             not_found;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    cmd_kind_e kind;
    entry_t    entry;
    logic      code_bit;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/hsd_front.sv */
// request classification and command queue in front of the table search
`default_nettype none
module hsd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              full_o,
  input  wire hsd_pkg::in_t in_data_i,
  output logic              cmd_valid_o,
  output hsd_pkg::cmd_t     cmd_o,
  input  wire logic         cmd_ready_i
);

  hsd_pkg::cmd_t                queue_mem [hsd_pkg::QUEUE_DEPTH];
  logic [hsd_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hsd_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hsd_pkg::QCNT_W-1:0]   count_q, count_d;
  hsd_pkg::cmd_t                cmd_new;
  logic                         keep;
  logic                         wr_en;
  logic                         rd_en;

  always_comb begin
    cmd_new.entry.symbol = in_data_i.entry_symbol;
    cmd_new.entry.length = in_data_i.entry_length;
    cmd_new.entry.code   = in_data_i.entry_code;
    cmd_new.code_bit     = in_data_i.code_bit;
    cmd_new.kind         = hsd_pkg::CMD_BIT;
    keep                 = 1'b0;
    case (hsd_pkg::action_e'(in_data_i.action))
      hsd_pkg::ACT_CLEAR: begin
        cmd_new.kind = hsd_pkg::CMD_CLEAR;
        keep         = 1'b1;
      end
      hsd_pkg::ACT_LOAD: begin
        cmd_new.kind = hsd_pkg::CMD_LOAD;
        keep         = (in_data_i.entry_length != '0) &&
                       (32'(in_data_i.entry_length) <= hsd_pkg::MAX_CODE_BITS);
      end
      hsd_pkg::ACT_BIT: begin
        cmd_new.kind = hsd_pkg::CMD_BIT;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o      = (count_q == hsd_pkg::QCNT_W'(hsd_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_mem[rd_ptr_q];
  assign wr_en       = push_i && !full_o && keep;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == hsd_pkg::QPTR_W'(hsd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + hsd_pkg::QPTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == hsd_pkg::QPTR_W'(hsd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + hsd_pkg::QPTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + hsd_pkg::QCNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - hsd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

/* hdl/hsd_back.sv */
// code table storage and linear search sequencer
`default_nettype none
module hsd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire hsd_pkg::cmd_t                 cmd_i,
  output logic                               cmd_ready_o,
  input  wire logic [hsd_pkg::COUNT_W-1:0]   symbol_count_i,
  output logic                               res_valid_o,
  output hsd_pkg::out_t                      res_o,
  input  wire logic                          res_ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  logic [hsd_pkg::FILL_W-1:0]     fill_q;
  logic [hsd_pkg::LEN_W-1:0]      longest_q;
  logic [hsd_pkg::CODE_W-1:0]     acc_q;
  logic [hsd_pkg::LEN_W-1:0]      nbits_q;
  logic [hsd_pkg::COUNT_W-1:0]    decoded_q;
  logic                           finished_q;
  logic [hsd_pkg::IDX_W-1:0]      idx_q;
  hsd_pkg::out_t                  res_q;

  hsd_pkg::entry_t                table_mem [hsd_pkg::TABLE_DEPTH];
  hsd_pkg::entry_t                rd_data_q;
  logic [hsd_pkg::IDX_W-1:0]      rd_addr;
  logic                           wr_en;

  logic                           take;
  logic                           run;
  logic [hsd_pkg::CODE_W-1:0]     acc_next;
  logic [hsd_pkg::LEN_W-1:0]      nbits_next;
  logic [hsd_pkg::FILL_W-1:0]     idx_next;
  logic                           scan_end;
  logic                           hit;
  logic                           is_last;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign run         = !finished_q && (decoded_q < symbol_count_i);
  assign acc_next    = {acc_q[hsd_pkg::CODE_W-2:0], cmd_i.code_bit};
  assign nbits_next  = (nbits_q < hsd_pkg::LEN_W'(hsd_pkg::CODE_W))
                       ? nbits_q + hsd_pkg::LEN_W'(1) : nbits_q;
  assign idx_next    = hsd_pkg::FILL_W'(idx_q) + hsd_pkg::FILL_W'(1);
  assign scan_end    = (idx_next == fill_q);
  assign hit         = (rd_data_q.length == nbits_q) && (rd_data_q.code == acc_q);
  assign is_last     = ((decoded_q + hsd_pkg::COUNT_W'(1)) == symbol_count_i);
  assign rd_addr     = (state_q == ST_SCAN) ? idx_next[hsd_pkg::IDX_W-1:0] : '0;
  assign wr_en       = take && (cmd_i.kind == hsd_pkg::CMD_LOAD) &&
                       (fill_q < hsd_pkg::FILL_W'(hsd_pkg::TABLE_DEPTH));
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[fill_q[hsd_pkg::IDX_W-1:0]] <= cmd_i.entry;
    end
    rd_data_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      longest_q  <= '0;
      acc_q      <= '0;
      nbits_q    <= '0;
      decoded_q  <= '0;
      finished_q <= 1'b0;
      idx_q      <= '0;
      res_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            case (cmd_i.kind)
              hsd_pkg::CMD_CLEAR: begin
                fill_q     <= '0;
                longest_q  <= '0;
                acc_q      <= '0;
                nbits_q    <= '0;
                decoded_q  <= '0;
                finished_q <= 1'b0;
              end
              hsd_pkg::CMD_LOAD: begin
                if (wr_en) begin
                  fill_q <= fill_q + hsd_pkg::FILL_W'(1);
                  if (cmd_i.entry.length > longest_q) begin
                    longest_q <= cmd_i.entry.length;
                  end
                end
              end
              hsd_pkg::CMD_BIT: begin
                if (run) begin
                  acc_q   <= acc_next;
                  nbits_q <= nbits_next;
                  idx_q   <= '0;
                  if (fill_q != '0) begin
                    state_q <= ST_SCAN;
                  end else if (nbits_next >= longest_q) begin
                    acc_q   <= '0;
                    nbits_q <= '0;
                    res_q   <= '{symbol: '0, not_found: 1'b1, last: 1'b0};
                    state_q <= ST_EMIT;
                  end
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            acc_q     <= '0;
            nbits_q   <= '0;
            decoded_q <= decoded_q + hsd_pkg::COUNT_W'(1);
            res_q     <= '{symbol: rd_data_q.symbol, not_found: 1'b0, last: is_last};
            if (is_last) begin
              finished_q <= 1'b1;
            end
            state_q <= ST_EMIT;
          end else if (scan_end) begin
            if (nbits_q >= longest_q) begin
              acc_q   <= '0;
              nbits_q <= '0;
              res_q   <= '{symbol: '0, not_found: 1'b1, last: 1'b0};
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            idx_q <= idx_next[hsd_pkg::IDX_W-1:0];
          end
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= hsd_pkg::FILL_W'(hsd_pkg::TABLE_DEPTH))
    else $error("table fill count beyond depth");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (hsd_pkg::FILL_W'(idx_q) < fill_q))
    else $error("scan index outside loaded entries");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.kind == hsd_pkg::CMD_CLEAR) |=>
      (fill_q == '0 && decoded_q == '0 && !finished_q && nbits_q == '0))
    else $error("clear left state behind");

  a_finished_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (decoded_q != '0))
    else $error("stream finished without a decoded symbol");
`endif

endmodule
`default_nettype wire

/* hdl/hsd_result_buf.sv */
// two entry result queue toward the receiver
`default_nettype none
module hsd_result_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire hsd_pkg::out_t res_i,
  output logic               res_ready_o,
  output logic               empty_o,
  output hsd_pkg::out_t      out_data_o,
  input  wire logic          pop_i
);

  hsd_pkg::out_t               buf_mem [hsd_pkg::RES_DEPTH];
  logic [hsd_pkg::RPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [hsd_pkg::RPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [hsd_pkg::RCNT_W-1:0]  count_q, count_d;
  logic                        wr_en;
  logic                        rd_en;

  assign res_ready_o = (count_q != hsd_pkg::RCNT_W'(hsd_pkg::RES_DEPTH));
  assign empty_o     = (count_q == '0);
  assign out_data_o  = buf_mem[rd_ptr_q];
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == hsd_pkg::RPTR_W'(hsd_pkg::RES_DEPTH - 1)) ? '0
                 : wr_ptr_q + hsd_pkg::RPTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == hsd_pkg::RPTR_W'(hsd_pkg::RES_DEPTH - 1)) ? '0
                 : rd_ptr_q + hsd_pkg::RPTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + hsd_pkg::RCNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - hsd_pkg::RCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/huffman_table_search_decoder.sv */
// top level of the huffman table search decoder
//
// input side is a queue: a request is taken when push is high and full is low.
// a request clears the table and counters, loads one table entry, or feeds one
// code bit, msb first. requests pass through a four deep command queue, so the
// sender keeps pushing while the search runs.
// load, clear and code bit requests are taken by the back end one at a time. the
// table has one write port and one read port, and the search reads one entry
// per cycle in load order, stopping at the first match.
// results leave through a two deep queue: while empty is low the oldest result
// is on out_data_o and it is taken when pop is high. a stalled receiver fills
// that queue, then holds the search, then the command queue, then full rises.
// the symbol_count register is written on the cfg channel, which is always
// ready; write it only while no request is in flight.
// reset clears all counters, queues and symbol_count; no clearing pass runs,
// table contents stay undefined until loaded and their values are never used before that.
`default_nettype none
module huffman_table_search_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire hsd_pkg::in_t                 in_data_i,
  output logic                              empty,
  input  wire logic                         pop,
  output hsd_pkg::out_t                     out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hsd_pkg::COUNT_W-1:0]  cfg_data_i
);

  logic [hsd_pkg::COUNT_W-1:0] symbol_count_q;
  logic                        cmd_valid;
  hsd_pkg::cmd_t               cmd;
  logic                        cmd_ready;
  logic                        res_valid;
  hsd_pkg::out_t               res;
  logic                        res_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      symbol_count_q <= cfg_data_i;
    end
  end

  hsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  hsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_ready_o    (cmd_ready),
    .symbol_count_i (symbol_count_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  hsd_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .empty_o     (empty),
    .out_data_o  (out_data_o),
    .pop_i       (pop)
  );

endmodule
`default_nettype wire
